### rtl/ulcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulcv_pkg
// Shared types and constants for the UTF-8 Latin/Cyrillic Vigenere core.
// ----------------------------------------------------------------------------
package ulcv_pkg;

	localparam int KEY_SLOTS   = 8;
	localparam int SHIFT_W     = 6;
	localparam int SLOT_W      = $clog2(KEY_SLOTS);
	localparam int KEY_LEN_W   = 4;
	localparam int KEY_BITS_W  = 48;
	localparam int CFG_ADDR_W  = 5;
	localparam int CFG_DATA_W  = 64;

	localparam logic [10:0] CYR_UP_START = 11'h410;
	localparam logic [10:0] CYR_LO_START = 11'h430;
	localparam logic [10:0] CYR_UP_YO    = 11'h401;
	localparam logic [10:0] CYR_LO_YO    = 11'h451;
	localparam logic [10:0] CYR_UP_STOP  = 11'h42F;
	localparam logic [10:0] CYR_LO_STOP  = 11'h44F;
	localparam logic [5:0]  LATIN_SIZE   = 6'd26;
	localparam logic [5:0]  CYR_SIZE     = 6'd33;
	localparam logic [5:0]  YO_INDEX     = 6'd6;
	localparam logic [7:0]  LEAD2_MARK   = 8'hC0;
	localparam logic [7:0]  CONT_MARK    = 8'h80;
	localparam logic [7:0]  CONT_MASK    = 8'h3F;

	// register index = paddr[4:3]
	typedef enum logic [1:0] {
		CFG_ENCRYPT_MODE,
		CFG_KEY_LENGTH,
		CFG_KEY_SHIFTS
	} ulcv_cfg_idx_t;

	typedef struct packed {
		logic                  encrypt_mode;
		logic [KEY_LEN_W-1:0]  key_length;
		logic [KEY_BITS_W-1:0] key_shifts;
	} ulcv_cfg_t;

	// partially gathered symbol
	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  count;
		logic [2:0]  sym_len;
	} ulcv_held_t;

	// one symbol's worth of output bytes, byte 0 in the low bits
	typedef struct packed {
		logic [31:0] bytes;
		logic [1:0]  last_idx;
		logic        eom;
	} ulcv_group_t;

endpackage

### rtl/ulcv_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulcv_xform
// Gathers one UTF-8 byte into the current symbol, decodes a finished symbol,
// shifts Latin or Cyrillic letters by the key and re-encodes them.
// ----------------------------------------------------------------------------
module ulcv_xform
	import ulcv_pkg::*;
(
	input  logic [7:0]        data_byte,
	input  logic              end_of_message,
	input  ulcv_held_t        held,
	input  logic [SLOT_W-1:0] key_position,
	input  ulcv_cfg_t         cfg,
	output logic              produce,
	output ulcv_held_t        held_next,
	output logic [SLOT_W-1:0] key_position_next,
	output ulcv_group_t       group
);

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd1;
		if (b[7] == 1'b0) len = 3'd1;
		else if (b[7:5] == 3'b110) len = 3'd2;
		else if (b[7:4] == 4'b1110) len = 3'd3;
		else if (b[7:3] == 5'b11110) len = 3'd4;
		return len;
	endfunction

	// {hit, index} for one Cyrillic case
	function automatic logic [6:0] cyr_lookup(input logic [20:0] code,
			input logic [10:0] start, input logic [10:0] stop, input logic [10:0] yo);
		logic [6:0] r;
		r = 7'd0;
		if (code == {10'd0, yo}) r = {1'b1, YO_INDEX};
		else if (code >= {10'd0, start} && code <= {10'd0, start} + 21'd5)
			r = {1'b1, 6'(code - {10'd0, start})};
		else if (code >= {10'd0, start} + 21'd6 && code <= {10'd0, stop})
			r = {1'b1, 6'(code - {10'd0, start} + 21'd1)};
		return r;
	endfunction

	logic [5:0]          shift_tab [KEY_SLOTS];
	logic [31:0]         sym;
	logic [2:0]          n;
	logic [2:0]          first_len;
	logic                hold;
	logic [20:0]         code;
	logic [6:0]          cyr_up, cyr_lo;
	logic                is_latin, is_cyr, upper;
	logic [5:0]          idx, size, sh_raw, sh;
	logic [KEY_LEN_W-1:0] eff_len;
	logic [SLOT_W-1:0]   slot, slot_adv;
	logic [6:0]          sum;
	logic [5:0]          ni;
	logic [10:0]         nc, start;
	logic [7:0]          enc0, enc1;
	logic                enc_two;

	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			shift_tab[i] = cfg.key_shifts[SHIFT_W*i +: SHIFT_W];
		end
	end

	always_comb begin
		// gather
		sym = {8'h00, held.bytes};
		sym[{held.count, 3'b000} +: 8] = data_byte;
		n = {1'b0, held.count} + 3'd1;
		first_len = lead_length(data_byte);
		if (held.count == 2'd0) hold = (first_len > 3'd1) && !end_of_message;
		else hold = (n < held.sym_len) && !end_of_message;

		held_next = '0;
		if (hold) begin
			held_next.bytes = sym[23:0];
			held_next.count = n[1:0];
			held_next.sym_len = (held.count == 2'd0) ? first_len : held.sym_len;
		end

		// decode by bytes collected
		case (n)
			3'd1: code = {13'd0, sym[7:0]};
			3'd2: code = {10'd0, sym[4:0], sym[13:8]};
			3'd3: code = {5'd0, sym[3:0], sym[13:8], sym[21:16]};
			default: code = {sym[2:0], sym[13:8], sym[21:16], sym[29:24]};
		endcase

		// classify
		cyr_up = cyr_lookup(code, CYR_UP_START, CYR_UP_STOP, CYR_UP_YO);
		cyr_lo = cyr_lookup(code, CYR_LO_START, CYR_LO_STOP, CYR_LO_YO);
		is_latin = 1'b0;
		is_cyr = 1'b0;
		upper = 1'b0;
		idx = 6'd0;
		if (code >= 21'h41 && code <= 21'h5A) begin
			is_latin = 1'b1;
			upper = 1'b1;
			idx = 6'(code - 21'h41);
		end else if (code >= 21'h61 && code <= 21'h7A) begin
			is_latin = 1'b1;
			idx = 6'(code - 21'h61);
		end else if (cyr_up[6]) begin
			is_cyr = 1'b1;
			upper = 1'b1;
			idx = cyr_up[5:0];
		end else if (cyr_lo[6]) begin
			is_cyr = 1'b1;
			idx = cyr_lo[5:0];
		end
		size = is_latin ? LATIN_SIZE : CYR_SIZE;

		// key slot, clamped length
		if (cfg.key_length == '0) eff_len = KEY_LEN_W'(1);
		else if (cfg.key_length > KEY_LEN_W'(KEY_SLOTS)) eff_len = KEY_LEN_W'(KEY_SLOTS);
		else eff_len = cfg.key_length;
		slot = (KEY_LEN_W'(key_position) < eff_len) ? key_position : '0;
		slot_adv = (KEY_LEN_W'(slot) + KEY_LEN_W'(1) >= eff_len) ? '0 : slot + SLOT_W'(1);
		sh_raw = shift_tab[slot];

		// shift mod size; raw shift is below 64 so two subtracts at most
		if ({1'b0, sh_raw} >= {size, 1'b0}) sh = 6'({1'b0, sh_raw} - {size, 1'b0});
		else if (sh_raw >= size) sh = sh_raw - size;
		else sh = sh_raw;

		if (cfg.encrypt_mode) sum = {1'b0, idx} + {1'b0, sh};
		else sum = {1'b0, idx} + {1'b0, size} - {1'b0, sh};
		ni = (sum >= {1'b0, size}) ? 6'(sum - {1'b0, size}) : sum[5:0];

		// back to a code point
		start = upper ? CYR_UP_START : CYR_LO_START;
		if (is_latin) nc = (upper ? 11'h41 : 11'h61) + {5'd0, ni};
		else if (ni == YO_INDEX) nc = upper ? CYR_UP_YO : CYR_LO_YO;
		else if (ni < YO_INDEX) nc = start + {5'd0, ni};
		else nc = start + {5'd0, ni} - 11'd1;

		enc_two = (nc > 11'h7F);
		if (enc_two) begin
			enc0 = LEAD2_MARK | {3'b000, nc[10:6]};
			enc1 = CONT_MARK | ({2'b00, nc[5:0]} & CONT_MASK);
		end else begin
			enc0 = nc[7:0];
			enc1 = 8'h00;
		end

		produce = !hold;
		group.eom = end_of_message;
		if (is_latin || is_cyr) begin
			group.bytes = {16'h0000, enc1, enc0};
			group.last_idx = {1'b0, enc_two};
		end else begin
			group.bytes = sym;
			group.last_idx = 2'(n - 3'd1);
		end

		if (hold) key_position_next = key_position;
		else if (end_of_message) key_position_next = '0;
		else if (is_latin || is_cyr) key_position_next = slot_adv;
		else key_position_next = key_position;
	end

endmodule

### rtl/utf8_latin_cyrillic_vigenere_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_latin_cyrillic_vigenere_core
// Vigenere cipher over a UTF-8 byte stream for Latin and Cyrillic letters.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (data_byte, end_of_message) enter on in_valid/in_ready, one
//   per cycle. Output words (out_byte, run_last, message_done) leave on
//   out_valid/out_ready, one byte per cycle. run_last flags the final byte
//   produced by one input word; message_done flags the last byte of a message.
//   A word that only extends a multi-byte symbol produces nothing.
//   An accepted byte is registered; a finished symbol then enters the symbol
//   queue once it has room. Throughput: 1 word per cycle on both sides
//   while the receiver is ready; output bytes never outnumber input bytes,
//   and the four-entry symbol queue holds the short symbols that pile up
//   behind a long one being serialized, so a ready receiver never stalls
//   the input. If the receiver stalls, the queue fills and in_ready drops
//   as soon as a word that completes a symbol finds no room; words that
//   only extend a symbol still drain from the input register. Reset:
//   encrypt_mode=1, key_length=1, key_shifts=0, no symbol held, key
//   position 0, queue empty. Configuration goes over APB (64-bit data,
//   register i at byte address 8*i) and must be written only while idle;
//   the user must keep to this, as the core does not enforce it.
// ----------------------------------------------------------------------------
module utf8_latin_cyrillic_vigenere_core
	import ulcv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_message,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  run_last,
	output logic                  message_done
);

	// config registers
	ulcv_cfg_t         cfg_q;
	ulcv_cfg_idx_t     cfg_sel;
	logic              cfg_wr;

	// input register
	logic              valid_s1;
	logic [7:0]        data_byte_s1;
	logic              eom_s1;

	// symbol gather state
	ulcv_held_t        held_q;
	logic [SLOT_W-1:0] key_position_q;

	// transform results
	logic              produce;
	ulcv_held_t        held_next;
	logic [SLOT_W-1:0] key_position_next;
	ulcv_group_t       group;

	// four-entry symbol queue plus byte serializer
	ulcv_group_t       grp_q [4];
	logic [1:0]        wr_ptr_q, rd_ptr_q;
	logic [2:0]        fifo_cnt_q;
	logic [1:0]        byte_idx_q;
	ulcv_group_t       head;
	logic              out_fire, pop, push, fifo_room, s1_fire;

	// ---------------- APB ----------------
	assign pready  = 1'b1;
	assign cfg_sel = ulcv_cfg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_sel)
			CFG_ENCRYPT_MODE: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_q.encrypt_mode};
			CFG_KEY_LENGTH:   prdata = {{(CFG_DATA_W-KEY_LEN_W){1'b0}}, cfg_q.key_length};
			CFG_KEY_SHIFTS:   prdata = {{(CFG_DATA_W-KEY_BITS_W){1'b0}}, cfg_q.key_shifts};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.encrypt_mode <= 1'b1;
			cfg_q.key_length   <= KEY_LEN_W'(1);
			cfg_q.key_shifts   <= '0;
		end else if (cfg_wr) begin
			case (cfg_sel)
				CFG_ENCRYPT_MODE: cfg_q.encrypt_mode <= pwdata[0];
				CFG_KEY_LENGTH:   cfg_q.key_length   <= pwdata[KEY_LEN_W-1:0];
				CFG_KEY_SHIFTS:   cfg_q.key_shifts   <= pwdata[KEY_BITS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	assign out_valid = (fifo_cnt_q != 3'd0);
	assign out_fire  = out_valid && out_ready;
	assign pop       = out_fire && run_last;
	assign fifo_room = (fifo_cnt_q < 3'd4) || pop;
	// a word that produces nothing never waits on the queue
	assign s1_fire   = valid_s1 && (!produce || fifo_room);
	assign push      = s1_fire && produce;
	assign in_ready  = !valid_s1 || s1_fire;

	// ---------------- input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_byte_s1 <= data_byte;
			eom_s1       <= end_of_message;
		end
	end

	// ---------------- transform ----------------
	ulcv_xform u_xform (
		.data_byte         (data_byte_s1),
		.end_of_message    (eom_s1),
		.held              (held_q),
		.key_position      (key_position_q),
		.cfg               (cfg_q),
		.produce           (produce),
		.held_next         (held_next),
		.key_position_next (key_position_next),
		.group             (group)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q         <= '0;
			key_position_q <= '0;
		end else if (s1_fire) begin
			held_q         <= held_next;
			key_position_q <= key_position_next;
		end
	end

	// ---------------- symbol queue ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= 2'd0;
			rd_ptr_q   <= 2'd0;
			fifo_cnt_q <= 3'd0;
			byte_idx_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 2'd1;
			case ({push, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + 3'd1;
				2'b01:   fifo_cnt_q <= fifo_cnt_q - 3'd1;
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
			if (out_fire) byte_idx_q <= run_last ? 2'd0 : byte_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) grp_q[wr_ptr_q] <= group;
	end

	// ---------------- output serializer ----------------
	assign head         = grp_q[rd_ptr_q];
	assign out_byte     = head.bytes[{byte_idx_q, 3'b000} +: 8];
	assign run_last     = (byte_idx_q == head.last_idx);
	assign message_done = run_last && head.eom;

`ifndef SYNTHESIS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= 3'd4)
		else $error("symbol queue overflow");

	a_held_short: assert property (@(posedge clk) disable iff (!arst_n)
		held_q.count != 2'd0 |-> {1'b0, held_q.count} < held_q.sym_len)
		else $error("held symbol already complete");

	a_eom_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && eom_s1 |=> held_q.count == 2'd0 && key_position_q == '0)
		else $error("message end did not clear gather state");

	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && run_last |=> byte_idx_q == 2'd0)
		else $error("byte index not restarted after symbol");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && produce && fifo_cnt_q == 3'd4)
		else $error("input stalled without a full queue");
`endif

endmodule

### tb/ulcv_cipher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulcv_cipher_checker
// Watches the config, input and output ports of the Vigenere core, predicts
// every output word from the accepted input words and compares them in order.
// ----------------------------------------------------------------------------
module ulcv_cipher_checker
	import ulcv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic                  pready,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_message,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [7:0]            out_byte,
	input  logic                  run_last,
	input  logic                  message_done,
	output int                    bad_words,
	output int                    in_flight
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} cipher_word_t;

	// shadow of the config registers
	logic                  enc_mode;
	logic [KEY_LEN_W-1:0]  key_len;
	logic [KEY_BITS_W-1:0] key_bits;

	// symbol gathering and key rotation
	logic [23:0]       part_bytes;
	logic [1:0]        part_cnt;
	logic [2:0]        part_len;
	logic [SLOT_W-1:0] key_pos;

	cipher_word_t ciphered_q[$];
	cipher_word_t head;

	function automatic int lead_len(input logic [7:0] b);
		if (!b[7]) return 1;
		if (b[7:5] == 3'b110) return 2;
		if (b[7:4] == 4'b1110) return 3;
		if (b[7:3] == 5'b11110) return 4;
		return 1;
	endfunction

	// alphabet index of a Cyrillic letter of one case; YO sits at index 6
	function automatic bit cyr_index(input logic [20:0] code, input logic [10:0] lo,
			input logic [10:0] hi, input logic [10:0] yo, output int idx);
		idx = 0;
		if (code == 21'(yo)) begin
			idx = int'(YO_INDEX);
			return 1'b1;
		end
		if (code >= lo && code <= lo + 11'd5) begin
			idx = int'(code - lo);
			return 1'b1;
		end
		if (code >= lo + 11'd6 && code <= hi) begin
			idx = int'(code - lo) + 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic vigenere_step(input logic [7:0] b, input logic eom);
		logic [7:0]   sym [4];
		logic [7:0]   outb [4];
		logic [20:0]  code;
		int           n, nout, idx, size, shift, ni, nc, len, slot, start;
		logic         letter, latin, upper;
		cipher_word_t w;

		if (part_cnt == 2'd0) begin
			if (lead_len(b) > 1 && !eom) begin
				part_bytes = {16'h0, b};
				part_cnt   = 2'd1;
				part_len   = 3'(lead_len(b));
				return;
			end
			sym[0] = b;
			n      = 1;
		end else begin
			for (int i = 0; i < part_cnt; i++)
				sym[i] = part_bytes[8*i +: 8];
			sym[part_cnt] = b;
			n = part_cnt + 1;
			if (n < part_len && !eom) begin
				part_bytes[8*part_cnt +: 8] = b;
				part_cnt = 2'(n);
				return;
			end
		end
		part_bytes = '0;
		part_cnt   = '0;
		part_len   = '0;

		// decode by the number of bytes actually collected
		case (n)
			1: code = {13'h0, sym[0]};
			2: code = {10'h0, sym[0][4:0], sym[1][5:0]};
			3: code = {5'h0, sym[0][3:0], sym[1][5:0], sym[2][5:0]};
			default: code = {sym[0][2:0], sym[1][5:0], sym[2][5:0], sym[3][5:0]};
		endcase

		letter = 1'b1;
		latin  = 1'b1;
		upper  = 1'b1;
		idx    = 0;
		if (code >= 21'h41 && code <= 21'h5A) begin
			idx = int'(code) - 'h41;
		end else if (code >= 21'h61 && code <= 21'h7A) begin
			upper = 1'b0;
			idx   = int'(code) - 'h61;
		end else begin
			latin = 1'b0;
			if (!cyr_index(code, CYR_UP_START, CYR_UP_STOP, CYR_UP_YO, idx)) begin
				upper  = 1'b0;
				letter = cyr_index(code, CYR_LO_START, CYR_LO_STOP, CYR_LO_YO, idx);
			end
		end

		if (!letter) begin
			for (int i = 0; i < n; i++)
				outb[i] = sym[i];
			nout = n;
		end else begin
			size = latin ? int'(LATIN_SIZE) : int'(CYR_SIZE);
			len  = (key_len == 0) ? 1 : (key_len > KEY_SLOTS) ? KEY_SLOTS : int'(key_len);
			slot = (key_pos < len) ? int'(key_pos) : 0;
			key_pos = (slot + 1 >= len) ? '0 : SLOT_W'(slot + 1);
			shift = int'(key_bits[slot*SHIFT_W +: SHIFT_W]) % size;
			ni = enc_mode ? (idx + shift) % size : (idx + size - shift) % size;
			if (latin) begin
				nc = (upper ? 'h41 : 'h61) + ni;
			end else if (ni == YO_INDEX) begin
				nc = upper ? int'(CYR_UP_YO) : int'(CYR_LO_YO);
			end else begin
				start = upper ? int'(CYR_UP_START) : int'(CYR_LO_START);
				nc = (ni < YO_INDEX) ? start + ni : start + ni - 1;
			end
			// canonical re-encode, so an overlong letter may shrink
			if (nc <= 'h7F) begin
				outb[0] = nc[7:0];
				nout    = 1;
			end else begin
				outb[0] = LEAD2_MARK | 8'(nc >> 6);
				outb[1] = CONT_MARK | (8'(nc) & CONT_MASK);
				nout    = 2;
			end
		end

		if (eom)
			key_pos = '0;

		for (int i = 0; i < nout; i++) begin
			w.data = outb[i];
			w.last = (i == nout - 1);
			w.done = w.last && eom;
			ciphered_q = {ciphered_q, w};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_mode   = 1'b1;
			key_len    = 4'd1;
			key_bits   = '0;
			part_bytes = '0;
			part_cnt   = '0;
			part_len   = '0;
			key_pos    = '0;
			ciphered_q.delete();
			bad_words  = 0;
			in_flight  = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (ulcv_cfg_idx_t'(paddr[4:3]))
					CFG_ENCRYPT_MODE: enc_mode = pwdata[0];
					CFG_KEY_LENGTH:   key_len  = pwdata[KEY_LEN_W-1:0];
					CFG_KEY_SHIFTS:   key_bits = pwdata[KEY_BITS_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && in_ready)
				vigenere_step(data_byte, end_of_message);

			if (out_valid && out_ready) begin
				if (ciphered_q.size() == 0) begin
					bad_words++;
					$display("%0t: unexpected word: exp none, got byte %02h last %0b done %0b",
						$time, out_byte, run_last, message_done);
				end else begin
					head = ciphered_q.pop_front();
					if (head.data !== out_byte || head.last !== run_last ||
							head.done !== message_done) begin
						bad_words++;
						$display("%0t: mismatch: exp byte %02h last %0b done %0b, got byte %02h last %0b done %0b",
							$time, head.data, head.last, head.done,
							out_byte, run_last, message_done);
					end
				end
			end

			in_flight = ciphered_q.size();
		end
	end

endmodule

### tb/tb_utf8_latin_cyrillic_vigenere_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_latin_cyrillic_vigenere_core
// Self-checking bench for the UTF-8 Latin/Cyrillic Vigenere core: directed
// corner cases, then random well-formed messages mixed with broken and noisy
// byte sequences across several key settings and both cipher directions.
// ----------------------------------------------------------------------------
module tb_utf8_latin_cyrillic_vigenere_core
	import ulcv_pkg::*;
();

	localparam int HALF_PERIOD = 2;
	localparam int SETTLE      = 8;     // slack for the core to settle
	localparam int HOLD_CYCLES = 60;    // long receiver stall to back up the core
	localparam int QUIET_LIMIT = 2000;  // cycles with no word moving on either side
	localparam int CHUNK_ITEMS = 10;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            data_byte;
	logic                  end_of_message;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            out_byte;
	logic                  run_last;
	logic                  message_done;

	int bad_words;
	int in_flight;

	// stimulus knobs, percent of cycles spent idle on each side
	int   snd_idle;
	int   rcv_idle;
	logic hold_req;
	int   sent;
	int   quiet_cycles;

	// bytes of the message being sent
	logic [7:0] msg_q[$];

	always #(HALF_PERIOD) clk = ~clk;

	utf8_latin_cyrillic_vigenere_core u_dut (.*);

	ulcv_cipher_checker u_checker (.*);

	// ------------------------------------------------------------------------
	// APB write: setup phase, access phase, then psel is lowered before return so that a
	// following write never lowers and raises psel in the same step.
	// ------------------------------------------------------------------------
	task automatic cfg_write(input ulcv_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// One input word. Called at a falling edge; returns at the falling edge
	// after acceptance with valid still high, so back-to-back words keep it up.
	task automatic send_word(input logic [7:0] b, input logic eom);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= b;
		end_of_message <= eom;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Send msg_q, flagging end of message on its last byte when asked.
	task automatic send_run(input logic eom);
		foreach (msg_q[i])
			send_word(msg_q[i], eom && (i == msg_q.size() - 1));
		sent += msg_q.size();
	endtask

	// Wait until every predicted word is out, then give symbol-extending
	// words time to clear the input register before touching the config.
	task automatic drain();
		in_valid <= 1'b0;
		while (in_flight != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b);
		msg_q = {msg_q, b};
	endtask

	// UTF-8 encode in a chosen length; a short code in a long form is overlong
	task automatic put_code(input logic [20:0] c, input int nb);
		case (nb)
			1: add_byte(c[7:0]);
			2: begin
				add_byte({3'b110, c[10:6]});
				add_byte({2'b10, c[5:0]});
			end
			3: begin
				add_byte({4'b1110, c[15:12]});
				add_byte({2'b10, c[11:6]});
				add_byte({2'b10, c[5:0]});
			end
			default: begin
				add_byte({5'b11110, c[20:18]});
				add_byte({2'b10, c[17:12]});
				add_byte({2'b10, c[11:6]});
				add_byte({2'b10, c[5:0]});
			end
		endcase
	endtask

	function automatic logic [20:0] latin_letter();
		return ($urandom_range(0, 1) ? 21'h41 : 21'h61) + 21'($urandom_range(0, 25));
	endfunction

	// any of the 33 letters of either case, YO included
	function automatic logic [20:0] cyr_letter();
		int   i;
		logic up;
		i  = $urandom_range(0, 32);
		up = 1'($urandom_range(0, 1));
		if (i == YO_INDEX)
			return up ? 21'(CYR_UP_YO) : 21'(CYR_LO_YO);
		return 21'(up ? CYR_UP_START : CYR_LO_START) + 21'(i) - ((i > YO_INDEX) ? 21'd1 : 21'd0);
	endfunction

	// Mostly letters of both scripts; the rest are other symbols of every
	// length, overlong letters and raw noise bytes.
	task automatic add_symbol(output int nb);
		int          kind;
		logic [20:0] code;
		kind = $urandom_range(0, 11);
		nb   = 1;
		case (kind)
			0, 1, 2: code = latin_letter();
			3, 4, 5: begin
				code = cyr_letter();
				nb   = 2;
			end
			6: code = 21'($urandom_range(0, 'h7F));
			7: begin
				// around the Cyrillic block edges
				code = 21'($urandom_range('h3F0, 'h46F));
				nb   = 2;
			end
			8: begin
				code = 21'($urandom_range(0, 'hFFFF));
				nb   = 3;
			end
			9: begin
				code = 21'($urandom_range(0, 'h1FFFFF));
				nb   = 4;
			end
			10: begin
				if ($urandom_range(0, 1)) begin
					code = latin_letter();
					nb   = $urandom_range(2, 4);
				end else begin
					code = cyr_letter();
					nb   = $urandom_range(3, 4);
				end
			end
			default: code = 21'($urandom_range(0, 255));
		endcase
		put_code(code, nb);
	endtask

	// A message of a few symbols. Most end with the end flag, some of those
	// cut the last symbol short; the rest run on into the next message.
	task automatic send_message();
		int   nb;
		logic eom;
		msg_q.delete();
		eom = ($urandom_range(0, 4) != 0);
		repeat ($urandom_range(1, 6)) add_symbol(nb);
		if (eom && nb > 1 && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, nb - 1)) void'(msg_q.pop_back());
		send_run(eom);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random back-pressure, plus one long stall on request.
	// ------------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rcv_idle);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too long with no word moving means the core is stuck or
	// predicted words never arrived.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** utf8_latin_cyrillic_vigenere_core: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		in_valid       = 1'b0;
		data_byte      = '0;
		end_of_message = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		hold_req       = 1'b0;
		sent           = 0;
		snd_idle       = 13;
		rcv_idle       = 72;
		arst_n         = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: three-slot key with shifts 1, 32 and 63 (32 above the Latin
		// alphabet, 63 above both, so reduced modulo its size), encrypting.
		cfg_write(CFG_ENCRYPT_MODE, 64'd1);
		cfg_write(CFG_KEY_LENGTH, 64'd3);
		cfg_write(CFG_KEY_SHIFTS, 64'({6'd63, 6'd32, 6'd1}));

		// Latin edges, YO and ya, byte extremes, bad leads 0xFF and 0x80,
		// an unchecked continuation (C1 41 -> 'A'), a 3-byte overlong 'A',
		// and a 4-byte lead cut by the end flag that decodes to Cyrillic A.
		msg_q = '{8'h41, 8'h7A, 8'hD0, 8'h81, 8'hD1, 8'h8F, 8'h00, 8'hFF, 8'h80,
			8'hC1, 8'h41, 8'hE0, 8'h81, 8'h81, 8'hF0, 8'h90};
		send_run(1'b1);
		// key restarts; lone lead byte flushed by the end flag
		msg_q = '{8'h61, 8'hE2};
		send_run(1'b1);
		// left open so the key position survives the next setting
		msg_q = '{8'h62};
		send_run(1'b0);
		drain();

		// Decrypt with a zero key length (acts as one) and a key position
		// past the new length.
		cfg_write(CFG_ENCRYPT_MODE, 64'd0);
		cfg_write(CFG_KEY_LENGTH, 64'd0);
		msg_q = '{8'h61, 8'hD0, 8'h96};
		send_run(1'b1);
		drain();

		// Key length beyond the slot count, every shift at its maximum.
		cfg_write(CFG_ENCRYPT_MODE, 64'd1);
		cfg_write(CFG_KEY_LENGTH, 64'd15);
		cfg_write(CFG_KEY_SHIFTS, 64'hFFFF_FFFF_FFFF);
		msg_q = '{8'h59, 8'hD1, 8'h91};
		send_run(1'b1);

		// Random messages in chunks: slow receiver, then slow sender, then
		// full rate with one long receiver stall.
		for (int chunk = 0; chunk < 6; chunk++) begin
			drain();
			snd_idle = (chunk < 2) ? 13 : (chunk < 4) ? 72 : 0;
			rcv_idle = (chunk < 2) ? 72 : (chunk < 4) ? 13 : 0;
			case (chunk)
				0: begin
					cfg_write(CFG_ENCRYPT_MODE, 64'd1);
					cfg_write(CFG_KEY_LENGTH, 64'd8);
				end
				1: begin
					cfg_write(CFG_ENCRYPT_MODE, 64'd0);
					cfg_write(CFG_KEY_LENGTH, 64'd1);
				end
				default: begin
					cfg_write(CFG_ENCRYPT_MODE, 64'($urandom_range(0, 1)));
					cfg_write(CFG_KEY_LENGTH, 64'($urandom_range(1, 8)));
				end
			endcase
			if (chunk == 1)
				cfg_write(CFG_KEY_SHIFTS, 64'd0);
			else
				cfg_write(CFG_KEY_SHIFTS, {16'h0, 16'($urandom), 32'($urandom)});
			if (chunk == 4) begin
				// the receiver picks the request up at the next falling edge
				@(posedge clk);
				hold_req = 1'b1;
				@(negedge clk);
				@(posedge clk);
				hold_req = 1'b0;
				@(negedge clk);
			end
			sent = 0;
			while (sent < CHUNK_ITEMS)
				send_message();
		end

		drain();
		if (bad_words == 0)
			$display("** utf8_latin_cyrillic_vigenere_core: PASSED **");
		else
			$display("** utf8_latin_cyrillic_vigenere_core: FAILED **");
		$finish;
	end

endmodule
